// ----- hw/rtl/aligned_epoch_window_timer_assert.svh -----
// Assertion macros for the epoch window timer
`ifndef ALIGNED_EPOCH_WINDOW_TIMER_ASSERT_SVH
`define ALIGNED_EPOCH_WINDOW_TIMER_ASSERT_SVH

`ifndef SYNTH
`define AEWT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AEWT_NEVER(lbl, clk, rst, cond, msg) \
   `AEWT_ASSERT(lbl, clk, rst, !(cond), msg)
`else
`define AEWT_ASSERT(lbl, clk, rst, prop, msg)
`define AEWT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ----- hw/rtl/aewt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aewt_pkg;

   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 16;

   localparam logic [TIME_W-1:0]   CLOSE_INVALID = '1;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd60;
   localparam logic [PERIOD_W-1:0] OFFSET_RESET  = 16'd0;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   localparam logic [1:0] REG_PERIOD = 2'd0;
   localparam logic [1:0] REG_OFFSET = 2'd1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_DIFF = 5'b00100,
      ST_UPD  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic                start;
      logic [TIME_W-1:0]   dividend;
      logic [PERIOD_W-1:0] divisor;
   } mod_ctl_type;

   typedef struct packed {
      logic                done;
      logic [PERIOD_W-1:0] remainder;
   } mod_sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/aewt_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none

// restoring remainder, one dividend bit per cycle
module aewt_mod
   import aewt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mod_ctl_type ctl,
   output mod_sts_type      sts
);

   localparam int CNT_W = $clog2(TIME_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TIME_W-1:0]   x_ff, x_in;
   logic [PERIOD_W-1:0] p_ff, p_in;
   logic [PERIOD_W-1:0] r_ff, r_in;
   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W:0]   diff;

   always_comb begin
      trial   = {r_ff, x_ff[TIME_W-1]};
      diff    = trial - {1'b0, p_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      p_in    = p_ff;
      r_in    = r_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = ctl.dividend;
         p_in    = ctl.divisor;
         r_in    = '0;
      end else if (busy_ff) begin
         x_in   = {x_ff[TIME_W-2:0], 1'b0};
         r_in   = (trial >= {1'b0, p_ff}) ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      p_ff <= p_in;
      r_ff <= r_in;
   end

   assign sts.done      = done_ff;
   assign sts.remainder = r_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/aligned_epoch_window_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | handshake          | payload
// req     | in  | req_tvalid/tready  | tuser[1:0] cmd, tdata[31:0] now_time
// rsp     | out | rsp_tvalid/tready  | tuser[0] epoch_end, tdata close_out, span_out
// csr     | in  | csr_valid/ready    | csr_index, csr_data[15:0]
//
// A recomputing request (start, or a tick that reaches the close time) runs the
// 32-step serial remainder unit in DIV, then DIFF, UPD, OUT; other requests go to OUT.
// One request at a time; req_tready is high only while the sequencer is idle.
// A finished result waits in the output register while the next request is taken.
// Synchronous active-high reset; no clearing pass.
`include "aligned_epoch_window_timer_assert.svh"

module aligned_epoch_window_timer
   import aewt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // now_time
   input  wire logic [1:0]  req_tuser,   // cmd
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // close_out, span_out
   output      logic [0:0]  rsp_tuser,   // epoch_end
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   state_type           state_ff, state_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [PERIOD_W-1:0] off_ff, off_in;
   logic [TIME_W-1:0]   dlt_ff, dlt_in;
   logic [PERIOD_W-1:0] pmo_ff, pmo_in;
   logic                gt_ff, gt_in;
   logic                ended_ff, ended_in;
   logic [TIME_W-1:0]   close_ff, close_in;
   logic [TIME_W-1:0]   span_ff, span_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] offset_ff, offset_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_end_ff, rsp_end_in;
   logic [TIME_W-1:0]   rsp_close_ff, rsp_close_in;
   logic [TIME_W-1:0]   rsp_span_ff, rsp_span_in;
   logic [TIME_W-1:0]   req_now;
   mod_ctl_type         mod_ctl;
   mod_sts_type         mod_sts;

   aewt_mod u_mod (
      .clock (clock),
      .reset (reset),
      .ctl   (mod_ctl),
      .sts   (mod_sts)
   );

   assign req_now    = req_tdata[TIME_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      period_in = period_ff;
      offset_in = offset_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PERIOD: period_in = csr_data;
            REG_OFFSET: offset_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      now_in           = now_ff;
      rem_in           = rem_ff;
      off_in           = off_ff;
      dlt_in           = dlt_ff;
      pmo_in           = pmo_ff;
      gt_in            = gt_ff;
      ended_in         = ended_ff;
      close_in         = close_ff;
      span_in          = span_ff;
      rsp_end_in       = rsp_end_ff;
      rsp_close_in     = rsp_close_ff;
      rsp_span_in      = rsp_span_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      mod_ctl.start    = 1'b0;
      mod_ctl.dividend = req_now + {16'b0, offset_ff};
      mod_ctl.divisor  = period_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               now_in   = req_now;
               rem_in   = close_ff - req_now;
               ended_in = 1'b0;
               state_in = ST_OUT;
               case (req_tuser)
                  CMD_TICK: begin
                     if (req_now >= close_ff) begin
                        ended_in      = 1'b1;
                        mod_ctl.start = 1'b1;
                        state_in      = ST_DIV;
                     end
                  end
                  CMD_START: begin
                     mod_ctl.start = 1'b1;
                     state_in      = ST_DIV;
                  end
                  CMD_STOP: close_in = CLOSE_INVALID;
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (mod_sts.done) begin
               off_in   = (period_ff == '0) ? '0 : mod_sts.remainder;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            dlt_in   = {16'b0, off_ff} - rem_ff;
            pmo_in   = period_ff - off_ff;
            gt_in    = $signed(rem_ff) > $signed({16'b0, period_ff});
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (gt_ff) begin
               close_in = now_ff + {16'b0, pmo_ff};
               span_in  = {16'b0, pmo_ff};
            end else if (dlt_ff == '0) begin
               if (rem_ff[TIME_W-1] || rem_ff == '0) begin
                  close_in = now_ff + {16'b0, period_ff};
                  span_in  = {16'b0, period_ff};
               end
            end else begin
               close_in = now_ff + {16'b0, pmo_ff};
               span_in  = span_ff + dlt_ff;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_end_in   = ended_ff;
               rsp_close_in = close_ff;
               rsp_span_in  = span_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         offset_ff    <= OFFSET_RESET;
         close_ff     <= CLOSE_INVALID;
         span_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         offset_ff    <= offset_in;
         close_ff     <= close_in;
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      now_ff       <= now_in;
      rem_ff       <= rem_in;
      off_ff       <= off_in;
      dlt_ff       <= dlt_in;
      pmo_ff       <= pmo_in;
      gt_ff        <= gt_in;
      ended_ff     <= ended_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_close_ff <= rsp_close_in;
      rsp_span_ff  <= rsp_span_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_span_ff, rsp_close_ff};
   assign rsp_tuser[0] = rsp_end_ff;

   `AEWT_ASSERT(a_accept_leaves_idle, clock, reset, (req_tvalid && req_tready) |=> (state_ff != ST_IDLE), "request accepted but sequencer stayed idle")
   `AEWT_NEVER(a_done_outside_div, clock, reset, mod_sts.done && (state_ff != ST_DIV), "remainder done outside divide state")
   `AEWT_ASSERT(a_stop_invalidates, clock, reset, ((state_ff == ST_OUT) && (cmd_ff == CMD_STOP)) |-> (close_ff == CLOSE_INVALID), "stop did not invalidate window")

endmodule

`default_nettype wire
